// File: design/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply block.
// Used by mvm_mac, mvm_res_fifo and the top level. Depends on nothing.
package mvm_pkg;

    // Fixed field widths of the item and result beats
    localparam int VAL_W  = 16;
    localparam int IDX_W  = 10;
    localparam int ROW_W  = 16;
    localparam int SUM_W  = 42;
    localparam int ACC_W  = 43;
    localparam int COLS_W = 11;

    // Defaults for the top-level parameters
    localparam int VEC_DEPTH_DEF  = 1024;
    localparam int ELEM_WIDTH_DEF = 16;

    // Result queue depth; also the cap on results in flight
    localparam int RES_DEPTH = 4;

    // Register port
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // Item opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_MATRIX = 1'b1;

    // Per-element bookkeeping that travels alongside the MAC pipe
    typedef struct packed {
        logic             row_end;
        logic [ROW_W-1:0] row_idx;
        logic             last;
    } mvm_tag_t;

    // One finished row
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [ROW_W-1:0] row_idx;
        logic             last;
    } mvm_res_t;

endpackage

// File: design/mvm_vec_store.sv
// Vector store: single-port-write, single-port-read synchronous RAM
// with registered read data. Depends on nothing.
module mvm_vec_store #(
    parameter int VEC_DEPTH = 1024,
    parameter int DATA_W    = 16,
    localparam int AW       = $clog2(VEC_DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [VEC_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/mvm_mac.sv
// Multiply-accumulate pipe: aligns element with store read, multiplies,
// accumulates the row and emits the sum at row end. Depends on mvm_pkg.
module mvm_mac #(
    parameter int DATA_W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 issue,
    input  mvm_pkg::mvm_tag_t    issue_tag,
    input  logic [DATA_W-1:0]    issue_val,
    input  logic [DATA_W-1:0]    rd_data,
    output logic                 push,
    output mvm_pkg::mvm_res_t    push_res
);
    import mvm_pkg::*;

    localparam int PROD_W = 2 * DATA_W;

    logic                s1_valid_reg;
    mvm_tag_t            s1_tag_reg;
    logic [DATA_W-1:0]   s1_val_reg;
    logic                s2_valid_reg;
    mvm_tag_t            s2_tag_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    acc_next;
    logic [ACC_W-1:0]    acc_sum;

    // Stage 1 lines up with the store read; stage 2 holds the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= issue_tag;
        s1_val_reg <= issue_val;
        s2_tag_reg <= s1_tag_reg;
        prod_reg   <= PROD_W'(s1_val_reg) * PROD_W'(rd_data);
    end

    assign acc_sum = acc_reg + ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (s2_valid_reg)
        begin
            acc_next = s2_tag_reg.row_end ? '0 : acc_sum;
        end
    end

    assign push             = s2_valid_reg && s2_tag_reg.row_end;
    assign push_res.sum     = acc_sum[SUM_W-1:0];
    assign push_res.row_idx = s2_tag_reg.row_idx;
    assign push_res.last    = s2_tag_reg.last;

endmodule

// File: design/mvm_res_fifo.sv
// Small result queue between the MAC pipe and the output channel.
// Depends on mvm_pkg for the result type.
module mvm_res_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mvm_pkg::mvm_res_t push_res,
    input  logic              pop,
    output logic              head_valid,
    output mvm_pkg::mvm_res_t head_res
);
    import mvm_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mvm_res_t        slot_reg [DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   wptr_next;
    logic [PW-1:0]   rptr_reg;
    logic [PW-1:0]   rptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_res;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_res   = slot_reg[rptr_reg];

endmodule

// File: design/matrix_vector_multiply_top.sv
// Matrix-vector multiply, top level: register port, column/row counters,
// vector store, MAC pipe and result queue.
// Depends on mvm_pkg, mvm_vec_store, mvm_mac, mvm_res_fifo.
//
// Usage: program cols_in_use (byte address 0) and rows_in_use (address 4)
// through the APB-style port while idle. Then send opcode-0 beats to load
// vector entries, followed by the matrix as opcode-1 beats in row-major
// order. After the last column of each row one result beat carries
// row_sum, row_index and last_row; the row counter wraps after the last row.
// Throughput: one input beat per clock while in_stall is low, loads and matrix elements alike.
// A row's result is registered through the store read, the multiply and
// the accumulate into the result queue before it is offered.
// A four-entry result queue sits before the output; in_stall rises only
// when four results are outstanding, so a stalled receiver holds off the
// input after at most four rows. Reset clears counters, accumulator and
// queue and restores cols_in_use = 1024, rows_in_use = 1; the vector
// store is not cleared and must be loaded before use.
module matrix_vector_multiply_top #(
    parameter int VEC_DEPTH  = mvm_pkg::VEC_DEPTH_DEF,
    parameter int ELEM_WIDTH = mvm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mvm_pkg::PADDR_W-1:0] paddr,
    input  logic [mvm_pkg::PDATA_W-1:0] pwdata,
    output logic [mvm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [mvm_pkg::VAL_W-1:0]   element_value,
    input  logic [mvm_pkg::IDX_W-1:0]   vector_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mvm_pkg::SUM_W-1:0]   row_sum,
    output logic [mvm_pkg::ROW_W-1:0]   row_index,
    output logic                        last_row
);
    import mvm_pkg::*;

    localparam int AW     = $clog2(VEC_DEPTH);
    localparam int EXT_W  = (AW + 1 > COLS_W) ? AW + 1 : COLS_W;
    localparam int SW     = (ELEM_WIDTH < VAL_W) ? ELEM_WIDTH : VAL_W;
    localparam int PEND_W = $clog2(RES_DEPTH + 1);

    logic [COLS_W-1:0] cols_reg;
    logic [ROW_W-1:0]  rows_reg;
    logic [AW-1:0]     col_reg;
    logic [AW-1:0]     col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;

    logic              cfg_wr;
    logic              in_accept;
    logic              out_accept;
    logic              mat_accept;
    logic              load_accept;
    logic              idx_ok;
    logic [EXT_W-1:0]  cols_ext;
    logic [EXT_W-1:0]  depth_ext;
    logic [EXT_W-1:0]  cols_eff;
    logic [ROW_W-1:0]  rows_eff;
    logic              row_end;
    logic              is_last;
    logic [SW-1:0]     val_in;
    mvm_tag_t          issue_tag;
    logic [SW-1:0]     rd_data;
    logic              push;
    mvm_res_t          push_res;
    mvm_res_t          head_res;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_W'(1024);
            rows_reg <= ROW_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[REG_SEL_BIT])
                REG_COLS: cols_reg <= pwdata[COLS_W-1:0];
                REG_ROWS: rows_reg <= pwdata[ROW_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_SEL_BIT])
            REG_COLS: prdata = PDATA_W'(cols_reg);
            REG_ROWS: prdata = PDATA_W'(rows_reg);
            default:  prdata = '0;
        endcase
    end

    // Item decode
    assign in_accept   = in_valid && !in_stall;
    assign out_accept  = out_valid && !out_stall;
    assign val_in      = element_value[SW-1:0];
    assign depth_ext   = EXT_W'(VEC_DEPTH);
    assign idx_ok      = EXT_W'(vector_index) < depth_ext;
    assign mat_accept  = in_accept && (opcode == OP_MATRIX);
    assign load_accept = in_accept && (opcode == OP_LOAD) && idx_ok;

    // Zero acts as one, oversize clamps to the store depth
    assign cols_ext = EXT_W'(cols_reg);
    assign cols_eff = (cols_reg == '0) ? EXT_W'(1)
                    : ((cols_ext > depth_ext) ? depth_ext : cols_ext);
    assign rows_eff = (rows_reg == '0) ? ROW_W'(1) : rows_reg;

    assign row_end = (EXT_W'(col_reg) + EXT_W'(1)) >= cols_eff;
    assign is_last = ({1'b0, row_reg} + (ROW_W + 1)'(1)) >= {1'b0, rows_eff};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (mat_accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = is_last ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    // Results outstanding, from accept of a row's last element to output beat
    always_comb
    begin
        pend_next = pend_reg;
        if ((mat_accept && row_end) && !out_accept)
        begin
            pend_next = pend_reg + PEND_W'(1);
        end
        else if (out_accept && !(mat_accept && row_end))
        begin
            pend_next = pend_reg - PEND_W'(1);
        end
    end

    assign in_stall = (pend_reg == PEND_W'(RES_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
        end
    end

    assign issue_tag.row_end = row_end;
    assign issue_tag.row_idx = row_reg;
    assign issue_tag.last    = is_last;

    mvm_vec_store #(
        .VEC_DEPTH (VEC_DEPTH),
        .DATA_W    (SW)
    ) u_store (
        .clk     (clk),
        .wr_en   (load_accept),
        .wr_addr (AW'(vector_index)),
        .wr_data (val_in),
        .rd_en   (mat_accept),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    mvm_mac #(
        .DATA_W (SW)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (mat_accept),
        .issue_tag (issue_tag),
        .issue_val (val_in),
        .rd_data   (rd_data),
        .push      (push),
        .push_res  (push_res)
    );

    mvm_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_res   (push_res),
        .pop        (out_accept),
        .head_valid (out_valid),
        .head_res   (head_res)
    );

    assign row_sum   = head_res.sum;
    assign row_index = head_res.row_idx;
    assign last_row  = head_res.last;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix_vector_multiply_top: a directed script, then random phases.
// A behavioural row-sum predictor queues the expected row results. Depends on mvm_pkg and the RTL.
module tb_top;
    import mvm_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int RAND_ITEMS   = 950;
    localparam int QUIET_ITEMS  = 120;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [1:0] {STEP_ITEM, STEP_COLS, STEP_ROWS} step_kind_t;

    typedef struct {
        step_kind_t  kind;
        logic        op;
        logic [15:0] val;
        logic [9:0]  idx;
        bit          chk;
        mvm_res_t    want;
    } step_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel, penable, pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata, prdata;
    logic                pready;
    logic                in_valid, in_stall;
    logic                opcode;
    logic [VAL_W-1:0]    element_value;
    logic [IDX_W-1:0]    vector_index;
    logic                out_valid, out_stall;
    logic [SUM_W-1:0]    row_sum;
    logic [ROW_W-1:0]    row_index;
    logic                last_row;

    // predictor state
    logic [VAL_W-1:0]    vec_copy [VEC_DEPTH_DEF];
    logic [ACC_W-1:0]    acc_model;
    logic [IDX_W-1:0]    col_model;
    logic [ROW_W-1:0]    row_model;
    logic [COLS_W-1:0]   cols_reg;
    logic [ROW_W-1:0]    rows_reg;

    mvm_res_t            pending_rows [$];
    mvm_res_t            want_row;
    step_t               script [$];
    int                  mismatches = 0;
    int                  cycle_count = 0;
    bit                  quiet = 1'b0;
    int                  gap_odds = 6;

    matrix_vector_multiply_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .element_value (element_value),
        .vector_index  (vector_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_sum       (row_sum),
        .row_index     (row_index),
        .last_row      (last_row)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Receiver: random stall bursts between free runs of varying length; never stalls once quiet
    initial
    begin : stall_gen
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
            begin
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (free_left > 0)
            begin
                out_stall <= 1'b0;
                free_left--;
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    out_stall  <= 1'b1;
                    stall_left = $urandom_range(0, 12);
                end
                else
                begin
                    out_stall <= 1'b0;
                    free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                            : $urandom_range(0, 40);
                end
            end
        end
    end

    // Result beats against the oldest expected row
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected row beat sum %h row %0d last %0b",
                             $realtime, row_sum, row_index, last_row);
            end
            else
            begin
                want_row = pending_rows.pop_front();
                if (row_sum !== want_row.sum || row_index !== want_row.row_idx ||
                    last_row !== want_row.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: row mismatch exp sum %h row %0d last %0b,",
                                  " got sum %h row %0d last %0b"},
                                 $realtime, want_row.sum, want_row.row_idx, want_row.last,
                                 row_sum, row_index, last_row);
                end
            end
        end
    end

    // One accepted item through the row-sum predictor
    task automatic predict_row(input logic op, input logic [15:0] val, input logic [9:0] idx,
                               output bit got, output mvm_res_t res);
        int  ncols;
        int  nrows;
        bit  fin;
        got = 1'b0;
        res = '0;
        if (op == OP_LOAD)
        begin
            vec_copy[idx] = val;
        end
        else
        begin
            ncols = (cols_reg == '0) ? 1
                  : ((int'(cols_reg) > VEC_DEPTH_DEF) ? VEC_DEPTH_DEF : int'(cols_reg));
            nrows = (rows_reg == '0) ? 1 : int'(rows_reg);
            acc_model = acc_model + ACC_W'(val) * ACC_W'(vec_copy[col_model]);
            if (int'(col_model) + 1 < ncols)
            begin
                col_model++;
            end
            else
            begin
                fin         = (int'(row_model) + 1 >= nrows);
                got         = 1'b1;
                res.sum     = acc_model[SUM_W-1:0];
                res.row_idx = row_model;
                res.last    = fin;
                acc_model   = '0;
                col_model   = '0;
                row_model   = fin ? '0 : row_model + ROW_W'(1);
            end
        end
    endtask

    // Drives one input beat after an optional random gap, waits for it to be taken, then queues its expected row
    task automatic send_beat(input logic op, input logic [15:0] val, input logic [9:0] idx,
                             input bit chk, input mvm_res_t typed);
        bit       got;
        mvm_res_t res;
        if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
        begin
            repeat ($urandom_range(1, 13))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        opcode        <= op;
        element_value <= val;
        vector_index  <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_row(op, val, idx, got, res);
        if (chk)
            pending_rows.push_back(typed);
        else if (got)
            pending_rows.push_back(res);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_reg(input logic which, input logic [PDATA_W-1:0] want);
        logic [PADDR_W-1:0] addr;
        logic [PDATA_W-1:0] got;
        addr = '0;
        addr[REG_SEL_BIT] = which;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: register %0d read exp %h got %h", $realtime, which, want, got);
        end
    endtask

    // Register write, only once the pipe has emptied
    task automatic set_reg(input logic which, input logic [PDATA_W-1:0] value);
        logic [PADDR_W-1:0] addr;
        logic [PDATA_W-1:0] kept;
        wait_drained();
        addr = '0;
        addr[REG_SEL_BIT] = which;
        kept = value & ((which == REG_COLS) ? 32'h0000_07FF : 32'h0000_FFFF);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == REG_COLS)
            cols_reg = kept[COLS_W-1:0];
        else
            rows_reg = kept[ROW_W-1:0];
        check_reg(which, kept);
    endtask

    task automatic add_step(input step_kind_t kind, input logic op, input logic [15:0] val,
                            input logic [9:0] idx, input bit chk, input logic [SUM_W-1:0] sum,
                            input logic [ROW_W-1:0] row, input logic fin);
        step_t s;
        s.kind         = kind;
        s.op           = op;
        s.val          = val;
        s.idx          = idx;
        s.chk          = chk;
        s.want.sum     = sum;
        s.want.row_idx = row;
        s.want.last    = fin;
        script.push_back(s);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'hFFFF;
            1: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        int k;
        int len;
        int eff;
        int rand_items;
        bit held_off;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        opcode        = OP_LOAD;
        element_value = '0;
        vector_index  = '0;
        acc_model     = '0;
        col_model     = '0;
        row_model     = '0;
        cols_reg      = 11'd1024;
        rows_reg      = 16'd1;
        rand_items    = 0;
        held_off      = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_reg(REG_COLS, 32'd1024);
        check_reg(REG_ROWS, 32'd1);

        // Two by two matrix, extremes of value and index, load in mid-row
        add_step(STEP_COLS, OP_LOAD,   16'd2,     10'd0,    0, '0, 0, 0);
        add_step(STEP_ROWS, OP_LOAD,   16'd2,     10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_LOAD,   16'hFFFF,  10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_LOAD,   16'hFFFF,  10'd1023, 0, '0, 0, 0);
        add_step(STEP_ITEM, OP_LOAD,   16'h0000,  10'd1,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_LOAD,   16'h0001,  10'd1,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'hFFFF,  10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_LOAD,   16'h0007,  10'd2,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'h0003,  10'd0,    1, 42'hFFFE0004, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'h0000,  10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'hFFFF,  10'd0,    1, 42'h0000FFFF, 1, 1);
        add_step(STEP_ITEM, OP_MATRIX, 16'h5555,  10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'hAAAA,  10'd1023, 0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'hFFFF,  10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'hFFFF,  10'd0,    1, 42'hFFFF0000, 1, 1);
        // zero counts act as one
        add_step(STEP_COLS, OP_LOAD,   16'd0,     10'd0,    0, '0, 0, 0);
        add_step(STEP_ROWS, OP_LOAD,   16'd0,     10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'hFFFF,  10'd0,    1, 42'hFFFE0001, 0, 1);
        add_step(STEP_ITEM, OP_MATRIX, 16'h1234,  10'd0,    0, '0, 0, 0);
        // shrink both counts below the counters part way through a matrix
        add_step(STEP_COLS, OP_LOAD,   16'd3,     10'd0,    0, '0, 0, 0);
        add_step(STEP_ROWS, OP_LOAD,   16'd3,     10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'h00FF,  10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'h0F0F,  10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'hF0F0,  10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'h8000,  10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'h0001,  10'd0,    0, '0, 0, 0);
        add_step(STEP_COLS, OP_LOAD,   16'd2,     10'd0,    0, '0, 0, 0);
        add_step(STEP_ROWS, OP_LOAD,   16'd1,     10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'h7FFF,  10'd0,    0, '0, 0, 0);
        add_step(STEP_COLS, OP_LOAD,   16'd1,     10'd0,    0, '0, 0, 0);
        add_step(STEP_ROWS, OP_LOAD,   16'hFFFF,  10'd0,    0, '0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'h0000,  10'd0,    1, 42'h0, 0, 0);
        add_step(STEP_ITEM, OP_MATRIX, 16'hFFFF,  10'd0,    1, 42'hFFFE0001, 1, 0);

        foreach (script[i])
        begin
            case (script[i].kind)
                STEP_COLS: set_reg(REG_COLS, 32'(script[i].val));
                STEP_ROWS: set_reg(REG_ROWS, 32'(script[i].val));
                default:   send_beat(script[i].op, script[i].val, script[i].idx,
                                     script[i].chk, script[i].want);
            endcase
        end

        // Full-width vector; row counter is ahead of the new row count here
        set_reg(REG_COLS, 32'd1024);
        set_reg(REG_ROWS, 32'd1);
        for (k = 0; k < VEC_DEPTH_DEF; k++)
            send_beat(OP_LOAD, 16'hFFFF, 10'(k), 1'b0, '0);
        for (k = 0; k < VEC_DEPTH_DEF; k++)
            send_beat(OP_MATRIX, pick_value(), 10'($urandom), 1'b0, '0);

        // Column count above the store depth clamps; all-ones row gives the largest sum
        set_reg(REG_COLS, 32'd2047);
        for (k = 0; k < VEC_DEPTH_DEF - 1; k++)
            send_beat(OP_MATRIX, 16'hFFFF, 10'd0, 1'b0, '0);
        send_beat(OP_MATRIX, 16'hFFFF, 10'd0, 1'b1, '{42'h3FF_F800_0400, 16'd0, 1'b1});

        while (rand_items < RAND_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:       set_reg(REG_COLS, 32'd0);
                1, 2:    set_reg(REG_COLS, 32'($urandom_range(13, 64)));
                default: set_reg(REG_COLS, 32'($urandom_range(1, 12)));
            endcase
            case ($urandom_range(0, 15))
                0:       set_reg(REG_ROWS, 32'd0);
                1:       set_reg(REG_ROWS, 32'hFFFF);
                2:       set_reg(REG_ROWS, 32'($urandom_range(0, 65535)));
                default: set_reg(REG_ROWS, 32'($urandom_range(1, 6)));
            endcase
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 8;
            endcase
            eff = (cols_reg == '0) ? 1
                : ((int'(cols_reg) > VEC_DEPTH_DEF) ? VEC_DEPTH_DEF : int'(cols_reg));
            // fresh vector for this matrix half the time, then the rows
            if ($urandom_range(0, 1) == 1)
            begin
                for (k = 0; k < eff; k++)
                begin
                    send_beat(OP_LOAD, pick_value(), 10'(k), 1'b0, '0);
                    rand_items++;
                end
            end
            len = $urandom_range(8, 72);
            for (k = 0; k < len; k++)
            begin
                if (!held_off && rand_items >= RAND_ITEMS / 2)
                begin
                    held_off = 1'b1;
                    wait_drained();
                end
                if ($urandom_range(0, 9) == 0)
                    send_beat(OP_LOAD, pick_value(), 10'($urandom_range(0, 1023)), 1'b0, '0);
                else
                    send_beat(OP_MATRIX, pick_value(), 10'($urandom), 1'b0, '0);
                rand_items++;
                if (rand_items >= RAND_ITEMS - QUIET_ITEMS)
                    quiet = 1'b1;
            end
        end

        wait_drained();
        if (mismatches == 0 && pending_rows.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
